FILE: hw/rtl/ugs_pkg.sv
package ugs_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_DEL_EDGE   = 2'd2,
    OP_DEL_VERTEX = 2'd3
  } op_t;

  // Status codes
  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_VERTEX    = 3'd1,
    ST_NO_EDGE       = 3'd2,
    ST_EDGE_EXISTS   = 3'd3,
    ST_VERTEX_EXISTS = 3'd4,
    ST_FULL          = 3'd5
  } reply_code_t;

  localparam int unsigned PORT_ID_W = 16;
  localparam int unsigned VCOUNT_W  = 7;
  localparam int unsigned ECOUNT_W  = 12;

endpackage

FILE: hw/rtl/undirected_graph_store_top.sv
// Channel   Signals                                          Direction
// request   start, busy, operation, vertex_a, vertex_b       in (busy out)
// result    done, status, vertex_count, edge_count           out
//
// A request is taken when start is high and busy is low. Every request
// first scans the id memory, one slot a cycle, then decides in S_DECIDE.
// Add vertex then replies; an edge request adds a read-modify-write of one
// or two adjacency rows; remove vertex walks every adjacency row through
// the row memory port. The result is shown one cycle with done high.
// rst is synchronous; the memories need no clearing, since slot valid bits
// gate every read of them. done cannot be stalled.
module undirected_graph_store_top #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned ID_BITS      = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] vertex_a,
  input  logic [15:0] vertex_b,
  output logic        done,
  output logic [2:0]  status,
  output logic [6:0]  vertex_count,
  output logic [11:0] edge_count
);

  localparam int unsigned IDX_W  = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned VC_W   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EC_W   = $clog2(MAX_VERTICES * (MAX_VERTICES + 1) / 2 + 1);
  localparam int unsigned KEEP_W = (ID_BITS < ugs_pkg::PORT_ID_W) ? ID_BITS
                                                                  : ugs_pkg::PORT_ID_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_VERTICES);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCAN   = 9'b000000010,
    S_DECIDE = 9'b000000100,
    S_CHKA   = 9'b000001000,
    S_WRB    = 9'b000010000,
    S_VROW   = 9'b000100000,
    S_WALK   = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_REPLY  = 9'b100000000
  } state_t;

  state_t                state, state_next;
  ugs_pkg::op_t          op;
  logic [ID_BITS-1:0]    id_a, id_b;
  ugs_pkg::reply_code_t  st;
  logic [VC_W-1:0]       vcount;
  logic [EC_W-1:0]       ecount;
  logic [MAX_VERTICES-1:0] used;

  // scan / walk control
  logic [CNT_W-1:0]      cnt;
  logic                  pv;
  logic [IDX_W-1:0]      pidx;
  logic                  found_a, found_b, free_found;
  logic [IDX_W-1:0]      slot_a, slot_b, free_slot;
  logic [MAX_VERTICES-1:0] row_v;

  // memories
  logic [ID_BITS-1:0]      id_mem  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [ID_BITS-1:0]      id_rd;
  logic [MAX_VERTICES-1:0] adj_rd;
  logic [IDX_W-1:0]        adj_raddr, adj_waddr;
  logic [MAX_VERTICES-1:0] adj_wdata;
  logic                    adj_we, id_we;
  logic [MAX_VERTICES-1:0] mask_a, mask_b;
  logic                    bit_ab;

  assign mask_a = MAX_VERTICES'(1) << slot_a;
  assign mask_b = MAX_VERTICES'(1) << slot_b;
  assign bit_ab = adj_rd[slot_b];

  // Id memory: read during the scan, written on vertex add
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[free_slot] <= id_a;
    end
    id_rd <= id_mem[cnt[IDX_W-1:0]];
  end

  // Adjacency row memory
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rd <= adj_mem[adj_raddr];
  end

  // Next state and memory port control
  always_comb begin
    state_next = state;
    adj_raddr  = cnt[IDX_W-1:0];
    adj_waddr  = pidx;
    adj_wdata  = adj_rd & ~mask_a;
    adj_we     = 1'b0;
    id_we      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (pv && pidx == IDX_W'(MAX_VERTICES - 1)) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        adj_raddr = slot_a;
        unique case (op)
          ugs_pkg::OP_ADD_VERTEX: begin
            state_next = S_REPLY;
            if (!found_a && free_found) begin
              id_we     = 1'b1;
              adj_we    = 1'b1;
              adj_waddr = free_slot;
              adj_wdata = '0;
            end
          end
          ugs_pkg::OP_ADD_EDGE, ugs_pkg::OP_DEL_EDGE: begin
            state_next = (found_a && found_b) ? S_CHKA : S_REPLY;
          end
          default: begin
            state_next = found_a ? S_VROW : S_REPLY;
          end
        endcase
      end
      S_CHKA: begin
        adj_raddr  = slot_b;
        adj_waddr  = slot_a;
        state_next = S_REPLY;
        if (op == ugs_pkg::OP_ADD_EDGE && !bit_ab) begin
          adj_we    = 1'b1;
          adj_wdata = adj_rd | mask_b;
          if (slot_a != slot_b) state_next = S_WRB;
        end else if (op == ugs_pkg::OP_DEL_EDGE && bit_ab) begin
          adj_we    = 1'b1;
          adj_wdata = adj_rd & ~mask_b;
          if (slot_a != slot_b) state_next = S_WRB;
        end
      end
      S_WRB: begin
        adj_we     = 1'b1;
        adj_waddr  = slot_b;
        adj_wdata  = (op == ugs_pkg::OP_ADD_EDGE) ? (adj_rd | mask_a) : (adj_rd & ~mask_a);
        state_next = S_REPLY;
      end
      S_VROW: begin
        state_next = S_WALK;
      end
      S_WALK: begin
        // read row cnt, write back row pidx with the removed vertex's bit cleared
        adj_we = pv;
        if (pv && pidx == IDX_W'(MAX_VERTICES - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        adj_we     = 1'b1;
        adj_waddr  = slot_a;
        adj_wdata  = '0;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      used   <= '0;
      vcount <= '0;
      ecount <= '0;
      pv     <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op         <= ugs_pkg::op_t'(operation);
            id_a       <= ID_BITS'(vertex_a[KEEP_W-1:0]);
            id_b       <= ID_BITS'(vertex_b[KEEP_W-1:0]);
            cnt        <= '0;
            pv         <= 1'b0;
            found_a    <= 1'b0;
            found_b    <= 1'b0;
            free_found <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cnt != LAST_CNT) cnt <= cnt + 1'b1;
          pv   <= (cnt != LAST_CNT);
          pidx <= cnt[IDX_W-1:0];
          if (pv) begin
            if (used[pidx] && id_rd == id_a && !found_a) begin
              found_a <= 1'b1;
              slot_a  <= pidx;
            end
            if (used[pidx] && id_rd == id_b && !found_b) begin
              found_b <= 1'b1;
              slot_b  <= pidx;
            end
            if (!used[pidx] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= pidx;
            end
          end
        end
        S_DECIDE: begin
          st <= ugs_pkg::ST_OK;
          unique case (op)
            ugs_pkg::OP_ADD_VERTEX: begin
              if (found_a) begin
                st <= ugs_pkg::ST_VERTEX_EXISTS;
              end else if (!free_found) begin
                st <= ugs_pkg::ST_FULL;
              end else begin
                used[free_slot] <= 1'b1;
                vcount          <= vcount + 1'b1;
              end
            end
            ugs_pkg::OP_ADD_EDGE, ugs_pkg::OP_DEL_EDGE: begin
              if (!(found_a && found_b)) st <= ugs_pkg::ST_BAD_VERTEX;
            end
            default: begin
              if (!found_a) st <= ugs_pkg::ST_BAD_VERTEX;
            end
          endcase
        end
        S_CHKA: begin
          if (op == ugs_pkg::OP_ADD_EDGE) begin
            if (bit_ab) st <= ugs_pkg::ST_EDGE_EXISTS;
            else        ecount <= ecount + 1'b1;
          end else begin
            if (!bit_ab)              st <= ugs_pkg::ST_NO_EDGE;
            else if (ecount != '0)    ecount <= ecount - 1'b1;
          end
        end
        S_VROW: begin
          row_v <= adj_rd;
          cnt   <= '0;
          pv    <= 1'b0;
        end
        S_WALK: begin
          if (cnt != LAST_CNT) cnt <= cnt + 1'b1;
          pv   <= (cnt != LAST_CNT);
          pidx <= cnt[IDX_W-1:0];
          if (pv && row_v[pidx] && ecount != '0) ecount <= ecount - 1'b1;
        end
        S_FIN: begin
          used[slot_a] <= 1'b0;
          if (vcount != '0) vcount <= vcount - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Outputs
  assign busy         = (state != S_IDLE);
  assign done         = (state == S_REPLY);
  assign status       = st;
  assign vertex_count = ugs_pkg::VCOUNT_W'(vcount);
  assign edge_count   = ugs_pkg::ECOUNT_W'(ecount);

  // Checks
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  a_vcount_max: assert property (@(posedge clk) disable iff (rst)
    vcount <= VC_W'(MAX_VERTICES))
    else $error("vertex count above capacity");
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (done && st == ugs_pkg::ST_FULL) |-> (vcount == VC_W'(MAX_VERTICES)))
    else $error("full reported below capacity");

endmodule

FILE: dv/graph_store_checker.sv
`timescale 1ns / 1ps
module graph_store_checker #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  operation,
  input  logic [15:0] vertex_a,
  input  logic [15:0] vertex_b,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [6:0]  vertex_count,
  input  logic [11:0] edge_count,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          held_now
);

  typedef struct packed {
    ugs_pkg::reply_code_t st;
    logic [6:0]           vcnt;
    logic [11:0]          ecnt;
  } graph_reply_t;

  // shadow of the graph
  logic                    used_q [MAX_VERTICES];
  logic [15:0]             id_q   [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_q  [MAX_VERTICES];
  int unsigned             nverts;
  int unsigned             nedges;
  graph_reply_t            reply_q[$];

  assign held_now = nverts;

  function automatic int slot_of(logic [15:0] id);
    for (int s = 0; s < MAX_VERTICES; s++)
      if (used_q[s] && id_q[s] == id) return s;
    return -1;
  endfunction

  // apply one request to the shadow and return the expected reply
  function automatic graph_reply_t apply_request(ugs_pkg::op_t op, logic [15:0] a,
                                                 logic [15:0] b);
    graph_reply_t r;
    int sa, sb, fs;
    sa = slot_of(a);
    sb = slot_of(b);
    fs = -1;
    r.st = ugs_pkg::ST_OK;
    case (op)
      ugs_pkg::OP_ADD_VERTEX: begin
        if (sa >= 0) r.st = ugs_pkg::ST_VERTEX_EXISTS;
        else begin
          for (int s = MAX_VERTICES - 1; s >= 0; s--)
            if (!used_q[s]) fs = s;
          if (fs < 0) r.st = ugs_pkg::ST_FULL;
          else begin
            used_q[fs] = 1'b1;
            id_q[fs]   = a;
            adj_q[fs]  = '0;
            nverts++;
          end
        end
      end
      ugs_pkg::OP_ADD_EDGE, ugs_pkg::OP_DEL_EDGE: begin
        if (sa < 0 || sb < 0) r.st = ugs_pkg::ST_BAD_VERTEX;
        else if (op == ugs_pkg::OP_ADD_EDGE) begin
          if (adj_q[sa][sb]) r.st = ugs_pkg::ST_EDGE_EXISTS;
          else begin
            adj_q[sa][sb] = 1'b1;
            adj_q[sb][sa] = 1'b1;
            nedges++;
          end
        end else begin
          if (!adj_q[sa][sb]) r.st = ugs_pkg::ST_NO_EDGE;
          else begin
            adj_q[sa][sb] = 1'b0;
            adj_q[sb][sa] = 1'b0;
            if (nedges > 0) nedges--;
          end
        end
      end
      default: begin
        if (sa < 0) r.st = ugs_pkg::ST_BAD_VERTEX;
        else begin
          for (int s = 0; s < MAX_VERTICES; s++)
            if (adj_q[sa][s]) begin
              adj_q[s][sa] = 1'b0;
              adj_q[sa][s] = 1'b0;
              if (nedges > 0) nedges--;
            end
          used_q[sa] = 1'b0;
          id_q[sa]   = '0;
          if (nverts > 0) nverts--;
        end
      end
    endcase
    r.vcnt = nverts[6:0];
    r.ecnt = nedges[11:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t checker: %s mismatch, got %0d expected %0d", $realtime, what, got,
             want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    graph_reply_t want;
    if (rst) begin
      for (int s = 0; s < MAX_VERTICES; s++) begin
        used_q[s] = 1'b0;
        id_q[s]   = '0;
        adj_q[s]  = '0;
      end
      nverts = 0;
      nedges = 0;
      reply_q.delete();
      pending      = 0;
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // result first: a reply never lands in the edge that takes its request
      if (done) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          $display("%0t checker: result transaction with nothing expected", $realtime);
          fail_count++;
        end else begin
          want = reply_q.pop_front();
          if (status !== want.st) report_mismatch("status", status, want.st);
          if (vertex_count !== want.vcnt)
            report_mismatch("vertex_count", vertex_count, want.vcnt);
          if (edge_count !== want.ecnt)
            report_mismatch("edge_count", edge_count, want.ecnt);
        end
      end
      if (start && !busy)
        reply_q.push_back(apply_request(ugs_pkg::op_t'(operation), vertex_a, vertex_b));
      pending = reply_q.size();
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned MAXV = 64;
  localparam int unsigned ITEM_CYCLES = 2 * MAXV + 10;
  localparam longint CYCLE_LIMIT = 1650 * 300 * 4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  operation = '0;
  logic [15:0] vertex_a = '0;
  logic [15:0] vertex_b = '0;
  logic        busy, done;
  logic [2:0]  status;
  logic [6:0]  vertex_count;
  logic [11:0] edge_count;
  int          fail_count, pending, results_seen, held_now;
  int          sender_idle_pct;
  longint      cycle_num = 0;
  logic [15:0] id_pool[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  undirected_graph_store_top #(.MAX_VERTICES(MAXV), .ID_BITS(16)) uut (
    .clk, .rst, .start, .busy, .operation, .vertex_a, .vertex_b,
    .done, .status, .vertex_count, .edge_count
  );

  graph_store_checker #(.MAX_VERTICES(MAXV)) chk (
    .clk, .rst, .start, .busy, .operation, .vertex_a, .vertex_b,
    .done, .status, .vertex_count, .edge_count,
    .fail_count, .pending, .results_seen, .held_now
  );

  // watchdog
  always @(posedge clk) begin
    cycle_num++;
    if (cycle_num > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_num);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // drive one request transaction once the block is free, with optional idle cycles
  task automatic send_request(ugs_pkg::op_t op, logic [15:0] a, logic [15:0] b);
    while (busy) @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) @(negedge clk);
    start     <= 1'b1;
    operation <= op;
    vertex_a  <= a;
    vertex_b  <= b;
    @(posedge clk);
    @(negedge clk);
    start     <= 1'b0;
    operation <= ugs_pkg::op_t'($urandom_range(3));
    vertex_a  <= 16'($urandom);
    vertex_b  <= 16'($urandom);
  endtask

  function automatic logic [15:0] pick_id();
    if (id_pool.size() != 0 && $urandom_range(99) < 85)
      return id_pool[$urandom_range(id_pool.size() - 1)];
    return 16'($urandom);
  endfunction

  initial begin
    ugs_pkg::op_t op;
    logic [15:0] a;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme ids, self loop, duplicates, errors
    sender_idle_pct = 0;
    send_request(ugs_pkg::OP_DEL_VERTEX, 16'h0000, 16'h0000);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'h0000, 16'hFFFF);
    send_request(ugs_pkg::OP_ADD_VERTEX, 16'h0000, 16'hFFFF);
    send_request(ugs_pkg::OP_ADD_VERTEX, 16'hFFFF, 16'h0000);
    send_request(ugs_pkg::OP_ADD_VERTEX, 16'h0000, 16'h1234);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'h0000, 16'h5555);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'h5555, 16'h0000);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'h0000, 16'hFFFF);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'hFFFF, 16'h0000);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'hFFFF, 16'hFFFF);
    send_request(ugs_pkg::OP_DEL_EDGE, 16'h0000, 16'h0000);
    send_request(ugs_pkg::OP_DEL_EDGE, 16'h0000, 16'hFFFF);
    send_request(ugs_pkg::OP_DEL_EDGE, 16'hFFFF, 16'h0000);
    send_request(ugs_pkg::OP_ADD_EDGE, 16'h0000, 16'h0000);
    send_request(ugs_pkg::OP_DEL_VERTEX, 16'h0000, 16'hAAAA);
    send_request(ugs_pkg::OP_DEL_EDGE, 16'hFFFF, 16'hFFFF);
    send_request(ugs_pkg::OP_DEL_EDGE, 16'hFFFF, 16'hFFFF);
    send_request(ugs_pkg::OP_DEL_VERTEX, 16'hFFFF, 16'h0000);

    // fill to capacity, then overflow
    for (int i = 0; i < MAXV; i++)
      send_request(ugs_pkg::OP_ADD_VERTEX, 16'(i * 1021 + 7), '0);
    send_request(ugs_pkg::OP_ADD_VERTEX, 16'hBEEF, '0);
    send_request(ugs_pkg::OP_ADD_VERTEX, 16'h0007, '0);
    for (int i = 0; i < MAXV; i++) id_pool.push_back(16'(i * 1021 + 7));

    // hold off until everything has come back
    while (pending != 0) @(negedge clk);

    // random: mostly requests on known ids, phases of sender idling
    for (int i = 0; i < 1550; i++) begin
      case ((i / 200) % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 62;
        2: sender_idle_pct = 11;
        default: sender_idle_pct = 0;
      endcase
      if (i == 800) while (pending != 0) @(negedge clk);
      op = ugs_pkg::op_t'($urandom_range(3));
      // keep the graph from running low so removals and edges stay interesting
      if (held_now < 20 && $urandom_range(1)) op = ugs_pkg::OP_ADD_VERTEX;
      a = pick_id();
      if (op == ugs_pkg::OP_ADD_VERTEX && $urandom_range(1)) begin
        a = 16'($urandom);
        id_pool.push_back(a);
        if (id_pool.size() > 96) id_pool.delete(0);
      end
      send_request(op, a, pick_id());
    end

    while (pending != 0) @(negedge clk);
    repeat (ITEM_CYCLES) @(posedge clk);
    $display("covered %0d result transactions: vertex/edge adds and removes, self loops,",
             results_seen);
    $display("duplicate, missing, unknown and full cases under several idle mixes");
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/ugs_pkg.sv
hw/rtl/undirected_graph_store_top.sv
dv/graph_store_checker.sv
dv/tb_top.sv
